// ===== rtl/lfu_pkg.sv =====
// lfu_pkg: shared constants and controller/datapath command and status types
// for the LFU cache. No dependencies.
`default_nettype none

package lfu_pkg;

    localparam int unsigned FIELD_W   = 32;     // width of key/value fields on the ports
    localparam int unsigned CAP_W     = 5;      // width of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic [FIELD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // capture request beat, clear accumulators
        logic scan_rd;    // read slot at index counter, search pass
        logic upd_rd;     // read slot at index counter, update pass
        logic finish;     // commit valid bit changes
        logic respond;    // load result register
    } lfu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;   // index counter at last slot
        logic is_get;     // captured request is a get
        logic out_free;   // result register can take a new beat
    } lfu_status_t;

endpackage

`default_nettype wire

// ===== rtl/lfu_if.sv =====
// lfu_req_if / lfu_rsp_if: valid/ready channels for request and result beats.
// No dependencies.
`default_nettype none

interface lfu_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic        [31:0] lookup_key;
    logic signed [31:0] write_value;

    modport source (output valid, mode, lookup_key, write_value, input ready);
    modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfu_ram.sv =====
// lfu_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module lfu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lfu_dp.sv =====
// lfu_dp: LFU cache datapath - slot RAM, valid bits, search accumulators,
// update logic and result register. Depends on lfu_pkg and lfu_ram.
`default_nettype none

module lfu_dp
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES     = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_mode,
    input  wire logic        [FIELD_W-1:0] req_key,
    input  wire logic signed [FIELD_W-1:0] req_value,
    input  wire logic                      cfg_we,
    input  wire logic        [CAP_W-1:0]   cfg_wdata,
    input  wire lfu_cmd_t                  cmd,
    output lfu_status_t                    status,
    input  wire logic                      rsp_ready,
    output logic                           rsp_valid,
    output logic                           rsp_hit,
    output logic signed      [FIELD_W-1:0] rsp_value
);

    localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RANK_W = IDX_W;
    localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int unsigned WORD_W = KEY_WIDTH + DATA_WIDTH + COUNT_WIDTH + RANK_W;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [DATA_WIDTH-1:0]  data;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [RANK_W-1:0]      rank;
    } slot_t;

    // request and config
    logic [CAP_W-1:0]      cap_reg;
    logic                  mode_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    // sweep control
    logic [IDX_W-1:0]   idx_reg;
    logic               d1_scan_reg;
    logic               d1_upd_reg;
    logic [IDX_W-1:0]   d1_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    // search results
    logic                   found_reg;
    logic [IDX_W-1:0]       f_idx_reg;
    logic [RANK_W-1:0]      f_rank_reg;
    logic [DATA_WIDTH-1:0]  f_data_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic                   free_any_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   vic_any_reg;
    logic [IDX_W-1:0]       vic_idx_reg;
    logic [COUNT_WIDTH-1:0] vic_cnt_reg;
    logic [RANK_W-1:0]      vic_rank_reg;

    // result register
    logic                     rsp_valid_reg;
    logic                     rsp_hit_reg;
    logic signed [FIELD_W-1:0] rsp_value_reg;

    // RAM
    slot_t             rd_word;
    slot_t             wr_word;
    logic              wr_en;
    logic [WORD_W-1:0] rd_bits;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (d1_idx_reg),
        .wr_data (wr_word),
        .rd_en   (cmd.scan_rd | cmd.upd_rd),
        .rd_addr (idx_reg),
        .rd_data (rd_bits)
    );

    assign rd_word = slot_t'(rd_bits);

    // per-slot view of the returning read
    logic slot_v;
    logic slot_match;
    logic slot_better;

    assign slot_v      = valid_reg[d1_idx_reg];
    assign slot_match  = slot_v && (rd_word.key == key_reg);
    assign slot_better = slot_v && (!vic_any_reg || (rd_word.cnt < vic_cnt_reg) ||
                         ((rd_word.cnt == vic_cnt_reg) && (rd_word.rank > vic_rank_reg)));

    // plan, stable once the search pass is over
    logic [CMP_W-1:0] cap_eff;
    logic             cap_zero;
    logic             do_touch;
    logic             do_write;
    logic             do_new;
    logic             do_evict;
    logic             do_insert;
    logic [IDX_W-1:0] ins_idx;

    always_comb
    begin
        cap_eff   = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
        cap_zero  = (cap_reg == '0);
        do_touch  = !cap_zero && found_reg;
        do_write  = do_touch && (mode_reg == MODE_SET);
        do_new    = !cap_zero && !found_reg && (mode_reg == MODE_SET);
        do_evict  = do_new && vic_any_reg && (CMP_W'(occ_reg) >= cap_eff);
        do_insert = do_new && (do_evict || free_any_reg);
        ins_idx   = (do_evict && (!free_any_reg || (vic_idx_reg < free_idx_reg))) ?
                    vic_idx_reg : free_idx_reg;
    end

    // update pass: rewrite each slot that changes
    always_comb
    begin
        wr_en   = 1'b0;
        wr_word = rd_word;
        if (d1_upd_reg)
        begin
            if (do_touch)
            begin
                if (d1_idx_reg == f_idx_reg)
                begin
                    wr_en        = 1'b1;
                    wr_word.data = do_write ? data_reg : rd_word.data;
                    wr_word.cnt  = (rd_word.cnt == '1) ? rd_word.cnt :
                                   rd_word.cnt + COUNT_WIDTH'(1);
                    wr_word.rank = '0;
                end
                else if (slot_v && (rd_word.rank < f_rank_reg))
                begin
                    wr_en        = 1'b1;
                    wr_word.rank = rd_word.rank + RANK_W'(1);
                end
            end
            else if (do_insert)
            begin
                if (d1_idx_reg == ins_idx)
                begin
                    wr_en        = 1'b1;
                    wr_word.key  = key_reg;
                    wr_word.data = data_reg;
                    wr_word.cnt  = COUNT_WIDTH'(1);
                    wr_word.rank = '0;
                end
                else if (slot_v && !(do_evict && (d1_idx_reg == vic_idx_reg)))
                begin
                    // age by one; slots older than the victim also close its gap
                    wr_en = 1'b1;
                    if (!(do_evict && (rd_word.rank > vic_rank_reg)))
                    begin
                        wr_word.rank = rd_word.rank + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.finish)
        begin
            if (do_evict)
            begin
                valid_next[vic_idx_reg] = 1'b0;
            end
            if (do_insert)
            begin
                valid_next[ins_idx] = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            idx_reg       <= '0;
            d1_scan_reg   <= 1'b0;
            d1_upd_reg    <= 1'b0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            free_any_reg  <= 1'b0;
            vic_any_reg   <= 1'b0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end

            if (cmd.scan_rd || cmd.upd_rd)
            begin
                idx_reg <= (idx_reg == IDX_W'(ENTRIES - 1)) ? '0 : idx_reg + IDX_W'(1);
            end
            d1_scan_reg <= cmd.scan_rd;
            d1_upd_reg  <= cmd.upd_rd;
            valid_reg   <= valid_next;

            if (cmd.load_req)
            begin
                found_reg    <= 1'b0;
                free_any_reg <= 1'b0;
                vic_any_reg  <= 1'b0;
                occ_reg      <= '0;
            end
            else if (d1_scan_reg)
            begin
                if (slot_v)
                begin
                    occ_reg <= occ_reg + OCC_W'(1);
                end
                if (slot_match && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!slot_v && !free_any_reg)
                begin
                    free_any_reg <= 1'b1;
                end
                if (slot_better)
                begin
                    vic_any_reg <= 1'b1;
                end
            end

            if (cmd.respond)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= req_mode;
            key_reg  <= KEY_WIDTH'(req_key);
            data_reg <= DATA_WIDTH'(req_value);
        end

        d1_idx_reg <= idx_reg;

        if (d1_scan_reg)
        begin
            if (slot_match && !found_reg)
            begin
                f_idx_reg  <= d1_idx_reg;
                f_rank_reg <= rd_word.rank;
                f_data_reg <= rd_word.data;
            end
            if (!slot_v && !free_any_reg)
            begin
                free_idx_reg <= d1_idx_reg;
            end
            if (slot_better)
            begin
                vic_idx_reg  <= d1_idx_reg;
                vic_cnt_reg  <= rd_word.cnt;
                vic_rank_reg <= rd_word.rank;
            end
        end

        if (cmd.respond)
        begin
            rsp_hit_reg   <= do_touch;
            rsp_value_reg <= do_touch ? FIELD_W'(signed'(f_data_reg)) : MISS_VALUE;
        end
    end

    assign status.idx_last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign status.is_get   = (mode_reg == MODE_GET);
    assign status.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_hit   = rsp_hit_reg;
    assign rsp_value = rsp_value_reg;

endmodule

`default_nettype wire

// ===== rtl/lfu_ctrl.sv =====
// lfu_ctrl: LFU cache sequencer - request accept, search pass, update pass,
// result hand-off. Depends on lfu_pkg.
`default_nettype none

module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire lfu_status_t status,
    output lfu_cmd_t         cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        SCAN_END,
        UPDATE,
        UPD_END,
        RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                cmd.load_req = req_valid;
                if (req_valid)
                begin
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.idx_last)
                begin
                    state_next = SCAN_END;
                end
            end
            SCAN_END:
            begin
                state_next = UPDATE;
            end
            UPDATE:
            begin
                cmd.upd_rd = 1'b1;
                if (status.idx_last)
                begin
                    state_next = UPD_END;
                end
            end
            UPD_END:
            begin
                cmd.finish = 1'b1;
                state_next = RESP;
            end
            RESP:
            begin
                if (!status.is_get)
                begin
                    state_next = IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == IDLE);

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_top.sv =====
// lfu_cache_top: LFU key-value cache, top level.
// Depends on lfu_pkg, lfu_if, lfu_ctrl, lfu_dp, lfu_ram.
`default_nettype none

// LFU key-value cache with ENTRIES slots. Each request beat on req is a set
// (mode 0) or a get (mode 1). A get returns one beat on rsp: hit and the stored
// value, or hit low and -1 on a miss; a set returns nothing. Hits bump a
// saturating use count and make the slot most recently used. A new key takes
// the lowest free slot; when occupancy has reached capacity_in_use (capped at
// ENTRIES) the slot with the lowest count is evicted first, ties going to the
// least recently used. Capacity 0 ignores sets and misses every get.
// All slot state lives in one single-port read / single-port write RAM, which
// the sequencer walks twice per request: one pass to find the key, occupancy,
// first free slot and LFU victim, one pass to rewrite counts and recency ranks.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed and
// requests are taken right after reset. A finished get waits in an output
// register, and the block holds in its final state only if that register is
// still full. capacity_in_use is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce it.

module lfu_cache_top
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES     = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    lfu_req_if.sink               req,
    lfu_rsp_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    lfu_cmd_t    cmd;
    lfu_status_t status;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lfu_dp #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_mode  (req.mode),
        .req_key   (req.lookup_key),
        .req_value (req.write_value),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_hit   (rsp.hit),
        .rsp_value (rsp.read_value)
    );

endmodule

`default_nettype wire

// ===== rtl/lfu_chk.sv =====
// lfu_chk: port-level checks for lfu_cache_top, attached by bind.
// Depends on lfu_pkg and lfu_cache_top.
`default_nettype none

module lfu_chk
    import lfu_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               rsp_hit,
    input wire logic [FIELD_W-1:0] rsp_value
);

    // result beat holds while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    // a miss always reports -1
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_value == MISS_VALUE)
        else $error("miss beat without -1 value");

    // the block is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    // no result can appear the cycle after a request is taken
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
        else $error("result beat without search");

endmodule

bind lfu_cache_top lfu_chk u_lfu_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp.hit),
    .rsp_value (rsp.read_value)
);

`default_nettype wire
